FILE: rtl/htb_pkg.sv
package htb_pkg;

  localparam int MAX_LEAVES_DEF = 32;
  localparam int LEAF_W         = 14;
  localparam int WEIGHT_W       = 19;
  localparam int IDX_W          = 6;
  localparam int CHILD_W        = 7;

  localparam logic signed [CHILD_W-1:0] NO_CHILD = -7'sd1;

  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

FILE: rtl/htb_ram.sv
module htb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/htb_min2.sv
module htb_min2 import htb_pkg::*; #(
  parameter int NODE_W = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  scan_ctl_t           ctl,
  input  logic [NODE_W-1:0]   idx,
  input  logic [WEIGHT_W-1:0] weight,
  output logic [NODE_W-1:0]   a_idx,
  output logic [NODE_W-1:0]   b_idx,
  output logic [WEIGHT_W-1:0] a_w,
  output logic [WEIGHT_W-1:0] b_w
);

  logic a_vld;
  logic b_vld;
  logic take_a;
  logic take_b;

  assign take_a = !a_vld || (weight < a_w);
  assign take_b = !b_vld || (weight < b_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (ctl.clear) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (ctl.sample) begin
      if (take_a) begin
        a_vld <= 1'b1;
        b_vld <= a_vld;
      end else if (take_b) begin
        b_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl.clear && ctl.sample) begin
      if (take_a) begin
        a_idx <= idx;
        a_w   <= weight;
        b_idx <= a_idx;
        b_w   <= a_w;
      end else if (take_b) begin
        b_idx <= idx;
        b_w   <= weight;
      end
    end
  end

  a_le_b: assert property (@(posedge clk) disable iff (rst)
    (a_vld && b_vld) |-> (a_w <= b_w))
    else $error("second minimum below first");

  b_needs_a: assert property (@(posedge clk) disable iff (rst)
    b_vld |-> a_vld)
    else $error("second minimum without first");

  clear_drops: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (!a_vld && !b_vld))
    else $error("clear did not drop minima");

endmodule

FILE: rtl/huffman_tree_builder.sv
// Leaves: one request per cycle, ready whenever no tree is being built or sent.
// Build of n leaves: merge of node i does one weight memory read per scanned node
// (nodes 0..i-1), then two parent writes, for i = n..2n-2.
// Output: 2n-1 nodes in index order, each read (S_RD), loaded (S_LD), then held until out_ready.
// Reset (rst, synchronous, active high) empties the leaf set and clears the flags;
// node memories are not cleared.
module huffman_tree_builder import htb_pkg::*; #(
  parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [LEAF_W-1:0]         leaf_weight,
  input  logic                      last_leaf,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic [IDX_W-1:0]          node_index,
  output logic [WEIGHT_W-1:0]       node_weight,
  output logic [IDX_W-1:0]          parent_index,
  output logic signed [CHILD_W-1:0] left_child,
  output logic signed [CHILD_W-1:0] right_child,
  output logic                      overflow_flag,
  output logic                      last_node,
  output logic                      out_valid,
  input  logic                      out_ready
);

  localparam int NODE_DEPTH = 2 * MAX_LEAVES - 1;
  localparam int NODE_W     = $clog2(2 * MAX_LEAVES);
  localparam int LC_W       = $clog2(MAX_LEAVES + 1);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WRA  = 3'd2;
  localparam logic [2:0] S_WRB  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_LD   = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;

  logic [2:0]              state;
  logic [LC_W-1:0]         leaf_count;
  logic                    dropped;
  logic [NODE_DEPTH-1:0]   has_parent;
  logic                    p_vld;
  logic [NODE_W-1:0]       p_idx;
  logic [NODE_W-1:0]       cur;
  logic [NODE_W-1:0]       last_idx;
  logic [NODE_W-1:0]       rd_addr;
  logic [NODE_W-1:0]       e_addr;

  logic                    room;
  logic                    store;
  logic [LC_W-1:0]         n_kept;
  logic [NODE_W:0]         two_n;
  logic [NODE_W-1:0]       leaf_slot;
  logic                    issue;

  scan_ctl_t               scan_ctl;
  logic [NODE_W-1:0]       a_idx;
  logic [NODE_W-1:0]       b_idx;
  logic [WEIGHT_W-1:0]     a_w;
  logic [WEIGHT_W-1:0]     b_w;

  logic                    w_we;
  logic [NODE_W-1:0]       w_waddr;
  logic [WEIGHT_W-1:0]     w_wdata;
  logic [NODE_W-1:0]       w_raddr;
  logic [WEIGHT_W-1:0]     w_rdata;
  logic                    p_we;
  logic [NODE_W-1:0]       p_waddr;
  logic [IDX_W-1:0]        p_rdata;
  logic [2*CHILD_W-1:0]    c_wdata;
  logic [2*CHILD_W-1:0]    c_rdata;

  assign in_ready  = (state == S_LOAD);
  assign room      = (leaf_count < LC_W'(MAX_LEAVES));
  assign store     = in_valid && in_ready && room;
  assign n_kept    = room ? leaf_count + LC_W'(1) : leaf_count;
  assign two_n     = (NODE_W + 1)'(n_kept) << 1;
  assign leaf_slot = NODE_W'(leaf_count);
  assign issue     = (rd_addr != cur);

  assign scan_ctl.clear  = (state == S_LOAD) || (state == S_WRB);
  assign scan_ctl.sample = p_vld && !has_parent[p_idx];

  assign w_we    = store || (state == S_WRA);
  assign w_waddr = (state == S_WRA) ? cur : leaf_slot;
  assign w_wdata = (state == S_WRA) ? a_w + b_w : WEIGHT_W'(leaf_weight);
  assign w_raddr = (state == S_SCAN) ? rd_addr : e_addr;

  assign p_we    = (state == S_WRA) || (state == S_WRB);
  assign p_waddr = (state == S_WRA) ? a_idx : b_idx;

  assign c_wdata = (state == S_WRA) ? {CHILD_W'(a_idx), CHILD_W'(b_idx)}
                                    : {NO_CHILD, NO_CHILD};

  htb_min2 #(
    .NODE_W (NODE_W)
  ) u_min2 (
    .clk    (clk),
    .rst    (rst),
    .ctl    (scan_ctl),
    .idx    (p_idx),
    .weight (w_rdata),
    .a_idx  (a_idx),
    .b_idx  (b_idx),
    .a_w    (a_w),
    .b_w    (b_w)
  );

  htb_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (NODE_DEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  htb_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NODE_DEPTH)
  ) u_parent_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (IDX_W'(cur)),
    .raddr (e_addr),
    .rdata (p_rdata)
  );

  htb_ram #(
    .WIDTH (2 * CHILD_W),
    .DEPTH (NODE_DEPTH)
  ) u_child_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (c_wdata),
    .raddr (e_addr),
    .rdata (c_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      leaf_count <= '0;
      dropped    <= 1'b0;
      has_parent <= '0;
      p_vld      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (room) begin
              has_parent[leaf_slot] <= 1'b0;
              leaf_count <= leaf_count + LC_W'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (last_leaf) begin
              state <= (n_kept == LC_W'(1)) ? S_RD : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          p_vld <= issue;
          if (!issue && !p_vld) begin
            state <= S_WRA;
          end
        end
        S_WRA: begin
          has_parent[a_idx] <= 1'b1;
          has_parent[b_idx] <= 1'b1;
          has_parent[cur]   <= 1'b0;
          state <= S_WRB;
        end
        S_WRB: begin
          state <= (cur == last_idx) ? S_RD : S_SCAN;
        end
        S_RD: begin
          state <= S_LD;
        end
        S_LD: begin
          out_valid <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_node) begin
              leaf_count <= '0;
              dropped    <= 1'b0;
              state <= S_LOAD;
            end else begin
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        if (in_valid && last_leaf) begin
          cur      <= NODE_W'(n_kept);
          last_idx <= NODE_W'(two_n - (NODE_W + 1)'(2));
          rd_addr  <= '0;
          e_addr   <= '0;
        end
      end
      S_SCAN: begin
        p_idx <= rd_addr;
        if (issue) begin
          rd_addr <= rd_addr + NODE_W'(1);
        end
      end
      S_WRB: begin
        cur     <= cur + NODE_W'(1);
        rd_addr <= '0;
      end
      S_LD: begin
        node_index    <= IDX_W'(e_addr);
        node_weight   <= w_rdata;
        parent_index  <= has_parent[e_addr] ? p_rdata : '0;
        left_child    <= $signed(c_rdata[2*CHILD_W-1:CHILD_W]);
        right_child   <= $signed(c_rdata[CHILD_W-1:0]);
        overflow_flag <= dropped;
        last_node     <= (e_addr == last_idx);
      end
      S_WAIT: begin
        if (out_ready && !last_node) begin
          e_addr <= e_addr + NODE_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  ready_not_sending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while a node is pending");

  count_in_range: assert property (@(posedge clk) disable iff (rst)
    leaf_count <= LC_W'(MAX_LEAVES))
    else $error("leaf count beyond capacity");

  distinct_children: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRA) |-> (a_idx != b_idx))
    else $error("merge picked the same node twice");

  children_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRA) |-> (!has_parent[a_idx] && !has_parent[b_idx]))
    else $error("merge picked a node that already has a parent");

endmodule

FILE: verif/tb_huffman_tree_builder.sv
`timescale 1ns / 1ps

module tb_huffman_tree_builder import htb_pkg::*; ();

  localparam int CAP   = MAX_LEAVES_DEF;
  localparam int DEPTH = 2 * CAP - 1;

  typedef struct packed {
    logic [IDX_W-1:0]          node_idx;
    logic [WEIGHT_W-1:0]       node_wt;
    logic [IDX_W-1:0]          parent_idx;
    logic signed [CHILD_W-1:0] left_idx;
    logic signed [CHILD_W-1:0] right_idx;
    logic                      overflow;
    logic                      root;
  } tree_node_t;

  typedef enum int {WT_ANY, WT_TINY, WT_TOP, WT_HIGH} weight_style_t;

  class tree_scoreboard;
    logic [WEIGHT_W-1:0]       weight_of [DEPTH];
    logic [IDX_W-1:0]          parent_of [DEPTH];
    logic signed [CHILD_W-1:0] left_of [DEPTH];
    logic signed [CHILD_W-1:0] right_of [DEPTH];
    bit                        linked [DEPTH];
    int                        held;
    bit                        dropped;
    tree_node_t                pending_nodes[$];
    int                        errors;

    function int smallest_free(int used, int skip);
      int best;
      bit found;
      best = 0;
      found = 0;
      for (int i = 0; i < used; i++) begin
        if (!linked[i] && i != skip && (!found || weight_of[i] < weight_of[best])) begin
          best = i;
          found = 1;
        end
      end
      return best;
    endfunction

    function void note_leaf(logic [LEAF_W-1:0] w, logic is_last);
      int total;
      int a;
      int b;
      tree_node_t nd;
      if (held < CAP) begin
        weight_of[held] = WEIGHT_W'(w);
        parent_of[held] = '0;
        left_of[held]   = NO_CHILD;
        right_of[held]  = NO_CHILD;
        linked[held]    = 0;
        held++;
      end else begin
        dropped = 1;
      end
      if (!is_last) return;
      total = 2 * held - 1;
      for (int i = held; i < total; i++) begin
        a = smallest_free(i, DEPTH);
        b = smallest_free(i, a);
        weight_of[i] = weight_of[a] + weight_of[b];
        parent_of[i] = '0;
        linked[i]    = 0;
        left_of[i]   = CHILD_W'(a);
        right_of[i]  = CHILD_W'(b);
        parent_of[a] = IDX_W'(i);
        parent_of[b] = IDX_W'(i);
        linked[a]    = 1;
        linked[b]    = 1;
      end
      for (int i = 0; i < total; i++) begin
        nd.node_idx   = IDX_W'(i);
        nd.node_wt    = weight_of[i];
        nd.parent_idx = parent_of[i];
        nd.left_idx   = left_of[i];
        nd.right_idx  = right_of[i];
        nd.overflow   = dropped;
        nd.root       = (i == total - 1);
        pending_nodes.push_back(nd);
      end
      held = 0;
      dropped = 0;
    endfunction

    function void check_node(tree_node_t got);
      tree_node_t want;
      if (pending_nodes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected node idx=%0d wt=%0d", got.node_idx, got.node_wt);
        return;
      end
      want = pending_nodes.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: node mismatch at %0t", $time);
          $display("  expected idx=%0d wt=%0d parent=%0d left=%0d right=%0d ovf=%0b last=%0b",
                   want.node_idx, want.node_wt, want.parent_idx, want.left_idx,
                   want.right_idx, want.overflow, want.root);
          $display("  actual   idx=%0d wt=%0d parent=%0d left=%0d right=%0d ovf=%0b last=%0b",
                   got.node_idx, got.node_wt, got.parent_idx, got.left_idx,
                   got.right_idx, got.overflow, got.root);
        end
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic [LEAF_W-1:0]         leaf_weight;
  logic                      last_leaf;
  logic                      in_valid;
  logic                      in_ready;
  logic [IDX_W-1:0]          node_index;
  logic [WEIGHT_W-1:0]       node_weight;
  logic [IDX_W-1:0]          parent_index;
  logic signed [CHILD_W-1:0] left_child;
  logic signed [CHILD_W-1:0] right_child;
  logic                      overflow_flag;
  logic                      last_node;
  logic                      out_valid;
  logic                      out_ready;

  tree_scoreboard sb = new();
  int  leaves_sent;
  int  hold_req;
  bit  calm;

  huffman_tree_builder u_dut (
    .clk           (clk),
    .rst           (rst),
    .leaf_weight   (leaf_weight),
    .last_leaf     (last_leaf),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .node_index    (node_index),
    .node_weight   (node_weight),
    .parent_index  (parent_index),
    .left_child    (left_child),
    .right_child   (right_child),
    .overflow_flag (overflow_flag),
    .last_node     (last_node),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic send_leaf(input logic [LEAF_W-1:0] w, input logic is_last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    leaf_weight <= w;
    last_leaf   <= is_last;
    do @(posedge clk); while (!in_ready);
    sb.note_leaf(w, is_last);
    leaves_sent++;
  endtask

  task automatic wait_for_drain();
    while (sb.pending_nodes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [LEAF_W-1:0] pick_weight(weight_style_t style);
    case (style)
      WT_ANY:  return LEAF_W'($urandom_range(0, 9999));
      WT_TINY: return LEAF_W'($urandom_range(0, 7));
      WT_TOP:  return LEAF_W'($urandom_range(9990, 9999));
      default: return LEAF_W'($urandom_range(8192, 9999));
    endcase
  endfunction

  initial begin : rx
    tree_node_t got;
    int hold_left;
    int stall_left;
    bit hold_done;
    out_ready <= 1'b0;
    hold_left = 0;
    stall_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = '{node_index, node_weight, parent_index, left_child, right_child,
                overflow_flag, last_node};
        sb.check_node(got);
      end
      if (hold_req > 0 && !hold_done) begin
        hold_left = hold_req;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stim
    int set_no;
    int set_len;
    int pick;
    weight_style_t style;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    leaf_weight <= '0;
    last_leaf   <= 1'b0;
    leaves_sent = 0;
    hold_req = 0;
    calm = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_leaf(14'd0, 1'b1);
    send_leaf(14'd9999, 1'b1);
    send_leaf(14'd7, 1'b0);
    send_leaf(14'd7, 1'b1);
    send_leaf(14'd9999, 1'b0);
    send_leaf(14'd9999, 1'b0);
    send_leaf(14'd9999, 1'b0);
    send_leaf(14'd0, 1'b1);
    send_leaf(14'd6143, 1'b0);
    send_leaf(14'd8192, 1'b0);
    send_leaf(14'd1, 1'b0);
    send_leaf(14'd1, 1'b0);
    send_leaf(14'd0, 1'b1);
    send_leaf(14'd3, 1'b0);
    send_leaf(14'd2, 1'b0);
    send_leaf(14'd1, 1'b0);
    send_leaf(14'd4, 1'b0);
    send_leaf(14'd5, 1'b0);
    send_leaf(14'd5, 1'b1);

    set_no = 0;
    while (leaves_sent < 500) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        set_len = CAP;
      else if (pick == 1)
        set_len = $urandom_range(CAP + 1, CAP + 4);
      else if (pick <= 4)
        set_len = $urandom_range(9, CAP - 1);
      else
        set_len = $urandom_range(1, 8);
      style = weight_style_t'($urandom_range(0, 3));
      if (set_no == 3) begin
        hold_req = 400;
        set_len = 12;
      end
      if (set_no == 7) begin
        in_valid <= 1'b0;
        wait_for_drain();
      end
      if (leaves_sent > 420) calm = 1;
      for (int i = 0; i < set_len; i++)
        send_leaf(pick_weight(style), i == set_len - 1);
      set_no++;
    end

    in_valid <= 1'b0;
    wait_for_drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_nodes.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
